/* hdl/deadband_dosing_controller_top_defines.svh */
// Assertion macros for the deadband dosing controller checker.
// Included by the checker file; needs a clk and rst in the including scope.
`ifndef DEADBAND_DOSING_CONTROLLER_TOP_DEFINES_SVH
`define DEADBAND_DOSING_CONTROLLER_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is high
`define DDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds across reset
`define DDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/ddc_pkg.sv */
// Shared types, codes and constants of the deadband dosing controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ddc_pkg;

  localparam int RING_DEPTH_DEF = 8;
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  // item kinds
  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_SAMPLE  = 2'd1,
    KIND_CONTROL = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  // dosing mode as seen on control_state
  typedef enum logic [1:0] {
    MODE_STABLE      = 2'd0,
    MODE_CONTROLLING = 2'd1,
    MODE_STABILIZING = 2'd2
  } mode_t;

  // pump direction codes
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_POINT     = 3'd0,
    REG_ERROR_MARGIN  = 3'd1,
    REG_SETTLE_MARGIN = 3'd2,
    REG_SETTLE_TIME   = 3'd3,
    REG_DOSE_TIME     = 3'd4,
    REG_SAMPLE_PERIOD = 3'd5,
    REG_PUMP_ENABLE   = 3'd6,
    REG_MANUAL_MODE   = 3'd7
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_DISPATCH,
    SEQ_SUM,
    SEQ_MUL,
    SEQ_QD,
    SEQ_FIX,
    SEQ_DECIDE,
    SEQ_FINISH
  } seq_state_t;

  // commands from sequencer to datapath
  typedef struct packed {
    logic latch;    // capture the accepted word
    logic tick;     // millisecond tick update
    logic sample;   // write ring entry, read old entry
    logic sum;      // running sum update
    logic mul;      // sum times reciprocal
    logic qd;       // quotient estimate times depth
    logic fix;      // quotient correction, write mean
    logic diff;     // error magnitude and sign
    logic decide;   // dosing state machine step
    logic load;     // load result register
  } cmd_t;

  // status from datapath to sequencer
  typedef struct packed {
    kind_t kind;
    logic  keep_sample;
  } status_t;

endpackage

`default_nettype wire

/* hdl/ddc_ctrl.sv */
// Sequencer of the deadband dosing controller: input/result handshake and
// datapath commands. Depends on ddc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output ddc_pkg::cmd_t         cmd,
  input  wire ddc_pkg::status_t stat
);
  import ddc_pkg::*;

  seq_state_t state, state_next;
  logic       result_valid_next;
  logic       slot_free;

  // result slot can take a new word when empty or being drained
  assign slot_free = !result_valid || result_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= SEQ_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next        = state;
    cmd               = '0;
    item_ready        = 1'b0;
    result_valid_next = result_valid && !result_ready;
    case (state)
      SEQ_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = SEQ_DISPATCH;
        end
      end
      SEQ_DISPATCH: begin
        case (stat.kind)
          KIND_TICK: begin
            cmd.tick   = 1'b1;
            state_next = SEQ_FINISH;
          end
          KIND_SAMPLE: begin
            if (stat.keep_sample) begin
              cmd.sample = 1'b1;
              state_next = SEQ_SUM;
            end else begin
              state_next = SEQ_FINISH;
            end
          end
          KIND_CONTROL: begin
            cmd.diff   = 1'b1;
            state_next = SEQ_DECIDE;
          end
          default: state_next = SEQ_FINISH;
        endcase
      end
      SEQ_SUM: begin
        cmd.sum    = 1'b1;
        state_next = SEQ_MUL;
      end
      SEQ_MUL: begin
        cmd.mul    = 1'b1;
        state_next = SEQ_QD;
      end
      SEQ_QD: begin
        cmd.qd     = 1'b1;
        state_next = SEQ_FIX;
      end
      SEQ_FIX: begin
        cmd.fix    = 1'b1;
        state_next = SEQ_FINISH;
      end
      SEQ_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = SEQ_FINISH;
      end
      SEQ_FINISH: begin
        // wait for the result slot, then publish
        if (slot_free) begin
          cmd.load          = 1'b1;
          result_valid_next = 1'b1;
          state_next        = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/ddc_datapath.sv */
// Datapath of the deadband dosing controller: config registers, sample ring,
// running sum and mean, timers, dosing mode and result register. Uses ddc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddc_datapath #(
  parameter int RING_DEPTH = ddc_pkg::RING_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ddc_pkg::cmd_t                  cmd,
  output ddc_pkg::status_t                    stat,
  input  wire logic [1:0]                     kind,
  input  wire logic [ddc_pkg::SAMPLE_W-1:0]   sample_value,
  input  wire logic                           cfg_valid,
  input  wire logic [ddc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ddc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [1:0]                          dose_direction,
  output logic                                pump_up_on,
  output logic                                pump_down_on,
  output logic [ddc_pkg::SAMPLE_W-1:0]        average_measure,
  output logic [1:0]                          control_state
);
  import ddc_pkg::*;

  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(RING_DEPTH);
  localparam int PROD_W = 2 * SUM_W + 1;
  // floor(2^SUM_W / depth): estimate is exact or one low
  localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'((64'd1 << SUM_W) / RING_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  // configuration
  logic [SAMPLE_W-1:0] set_point, error_margin, settle_margin, dose_time;
  logic [CNT_W-1:0]    settle_time, sample_period;
  logic [1:0]          pump_enable;
  logic                manual_mode;

  // captured word
  kind_t               kind_q;
  logic [SAMPLE_W-1:0] value_q;

  // ring and averaging
  logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_valid;
  logic [IDX_W-1:0]    wr_idx;
  logic [SAMPLE_W-1:0] old_rd;
  logic                old_valid;
  logic [SUM_W-1:0]    ring_sum;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    q_est;
  logic [SUM_W-1:0]    qd;
  logic [SUM_W-1:0]    rem;
  logic [SAMPLE_W-1:0] measure_mean;

  // timers and dosing
  logic [CNT_W-1:0]    since_sample, since_dose;
  logic [SAMPLE_W-1:0] pulse_remaining;
  dir_t                pulse_dir;
  mode_t               mode_state;
  dir_t                dose_dir;
  dir_t                dose_dir_next;
  logic [SAMPLE_W-1:0] mag;
  logic                err_pos, err_neg;
  logic                mean_nz;

  assign stat.kind        = kind_q;
  assign stat.keep_sample = since_sample > sample_period;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      set_point     <= '0;
      error_margin  <= '0;
      settle_margin <= '0;
      settle_time   <= '0;
      dose_time     <= '0;
      sample_period <= '0;
      pump_enable   <= '0;
      manual_mode   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_SET_POINT:     set_point     <= cfg_data[SAMPLE_W-1:0];
        REG_ERROR_MARGIN:  error_margin  <= cfg_data[SAMPLE_W-1:0];
        REG_SETTLE_MARGIN: settle_margin <= cfg_data[SAMPLE_W-1:0];
        REG_SETTLE_TIME:   settle_time   <= cfg_data[CNT_W-1:0];
        REG_DOSE_TIME:     dose_time     <= cfg_data[SAMPLE_W-1:0];
        REG_SAMPLE_PERIOD: sample_period <= cfg_data[CNT_W-1:0];
        REG_PUMP_ENABLE:   pump_enable   <= cfg_data[1:0];
        REG_MANUAL_MODE:   manual_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // word capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q  <= kind_t'(kind);
      value_q <= sample_value;
    end
  end

  // ring memory: read-first, one port
  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      ring_mem[wr_idx] <= value_q;
      old_rd           <= ring_mem[wr_idx];
    end
  end

  // ring valid bits and write pointer; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
      wr_idx     <= '0;
      old_valid  <= 1'b0;
    end else if (cmd.sample) begin
      ring_valid[wr_idx] <= 1'b1;
      old_valid          <= ring_valid[wr_idx];
      wr_idx             <= (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
    end
  end

  // running sum and mean (divide by depth via reciprocal, one correction)
  assign rem = ring_sum - qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_sum     <= '0;
      measure_mean <= '0;
    end else begin
      if (cmd.sum) begin
        ring_sum <= ring_sum + SUM_W'(value_q)
                    - (old_valid ? SUM_W'(old_rd) : '0);
      end
      if (cmd.fix) begin
        measure_mean <= (rem >= DEPTH_S) ? SAMPLE_W'(q_est + 1'b1) : SAMPLE_W'(q_est);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PROD_W'(ring_sum) * PROD_W'(RECIP);
    end
    if (cmd.qd) begin
      q_est <= prod[2*SUM_W-1:SUM_W];
      qd    <= SUM_W'(prod[2*SUM_W-1:SUM_W] * DEPTH_S);
    end
  end

  // error magnitude and sign
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      err_pos <= measure_mean > set_point;
      err_neg <= measure_mean < set_point;
      mag     <= (measure_mean >= set_point) ? measure_mean - set_point
                                             : set_point - measure_mean;
    end
  end

  assign mean_nz = measure_mean != '0;

  // direction a dose would take now
  always_comb begin
    dose_dir_next = DIR_NONE;
    if (err_pos && mean_nz && pump_enable[1]) begin
      dose_dir_next = DIR_DOWN;
    end else if (err_neg && mean_nz && pump_enable[0]) begin
      dose_dir_next = DIR_UP;
    end
  end

  // timers, pulse and dosing mode
  always_ff @(posedge clk) begin
    if (rst) begin
      since_sample    <= '0;
      since_dose      <= '0;
      pulse_remaining <= '0;
      pulse_dir       <= DIR_NONE;
      mode_state      <= MODE_STABLE;
      dose_dir        <= DIR_NONE;
    end else begin
      if (cmd.latch) begin
        dose_dir <= DIR_NONE;
      end
      if (cmd.sample) begin
        since_sample <= '0;
      end
      if (cmd.tick) begin
        if (since_sample != CNT_SAT) begin
          since_sample <= since_sample + 1'b1;
        end
        if (pulse_remaining != '0) begin
          pulse_remaining <= pulse_remaining - 1'b1;
          since_dose      <= '0;
          if (pulse_remaining == SAMPLE_W'(1)) begin
            pulse_dir <= DIR_NONE;
          end
        end else if (since_dose != CNT_SAT) begin
          since_dose <= since_dose + 1'b1;
        end
      end
      if (cmd.decide) begin
        if (manual_mode) begin
          mode_state <= MODE_STABLE;
        end else begin
          case (mode_state)
            MODE_STABLE: begin
              if (mag >= error_margin && mean_nz) begin
                mode_state <= MODE_CONTROLLING;
              end
            end
            MODE_CONTROLLING: begin
              if (mag >= settle_margin) begin
                dose_dir <= dose_dir_next;
                // a new dose replaces any running pulse
                if (dose_dir_next != DIR_NONE) begin
                  pulse_remaining <= dose_time;
                  pulse_dir       <= (dose_time == '0) ? DIR_NONE : dose_dir_next;
                end
                mode_state <= MODE_STABILIZING;
                since_dose <= '0;
              end else begin
                mode_state <= MODE_STABLE;
              end
            end
            MODE_STABILIZING: begin
              if (since_dose > settle_time) begin
                mode_state <= MODE_CONTROLLING;
              end
            end
            default: mode_state <= MODE_STABLE;
          endcase
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dose_direction  <= dose_dir;
      pump_up_on      <= (pulse_dir == DIR_UP) && (pulse_remaining != '0);
      pump_down_on    <= (pulse_dir == DIR_DOWN) && (pulse_remaining != '0);
      average_measure <= measure_mean;
      control_state   <= mode_state;
    end
  end

endmodule

`default_nettype wire

/* hdl/deadband_dosing_controller_top.sv */
// Per word: a tick is dispatched, then finished; a kept sample also runs the
// sum, multiply, quotient and fix steps of the mean divide; a dropped sample
// or unused kind goes to finish; a control step runs diff, then decide. Finish
// waits for a free result slot; the next word is taken the cycle after loading.
// Synchronous active-high reset clears config, ring (valid bits), timers,
// mean and dosing mode at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module deadband_dosing_controller_top #(
  parameter int RING_DEPTH = ddc_pkg::RING_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire logic [1:0]                     kind,
  input  wire logic [ddc_pkg::SAMPLE_W-1:0]   sample_value,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output logic [1:0]                          dose_direction,
  output logic                                pump_up_on,
  output logic                                pump_down_on,
  output logic [ddc_pkg::SAMPLE_W-1:0]        average_measure,
  output logic [1:0]                          control_state,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ddc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ddc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ddc_pkg::*;

  cmd_t    cmd;
  status_t stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  ddc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  ddc_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .kind            (kind),
    .sample_value    (sample_value),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .dose_direction  (dose_direction),
    .pump_up_on      (pump_up_on),
    .pump_down_on    (pump_down_on),
    .average_measure (average_measure),
    .control_state   (control_state)
  );

endmodule

`default_nettype wire

/* hdl/ddc_checker.sv */
// Port-level checker for the deadband dosing controller, bound to the top.
// Uses ddc_pkg and the macros in deadband_dosing_controller_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "deadband_dosing_controller_top_defines.svh"

module ddc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           result_valid,
  input wire logic                           result_ready,
  input wire logic [1:0]                     dose_direction,
  input wire logic                           pump_up_on,
  input wire logic                           pump_down_on,
  input wire logic [ddc_pkg::SAMPLE_W-1:0]   average_measure,
  input wire logic [1:0]                     control_state
);
  import ddc_pkg::*;

  logic                      stalled;
  logic                      dosed;
  logic                      dosed_up;
  logic [SAMPLE_W+5:0]       word_bits;

  assign stalled   = result_valid && !result_ready;
  assign dosed     = result_valid && (dose_direction != DIR_NONE);
  assign dosed_up  = result_valid && (dose_direction == DIR_UP);
  assign word_bits = {dose_direction, pump_up_on, pump_down_on, average_measure,
                      control_state};

  // a stalled result word holds
  `DDC_ASSERT(a_result_hold, stalled |=> result_valid && $stable(word_bits), "stalled word changed")

  // no result right after reset
  `DDC_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")

  // only one pump runs at a time
  `DDC_ASSERT(a_one_pump, result_valid |-> !(pump_up_on && pump_down_on), "both pumps on")

  // a dose always moves the machine to stabilizing
  `DDC_ASSERT(a_dose_state, dosed |-> control_state == MODE_STABILIZING, "dose without stabilizing")

  // an up dose just started cannot leave the down pump on
  `DDC_ASSERT(a_dose_replace, dosed_up |-> !pump_down_on, "down pump on after up dose")

endmodule

bind deadband_dosing_controller_top ddc_checker u_ddc_checker (.*);

`default_nettype wire

/* tb/tb_deadband_dosing_controller_top.sv */
// Self-checking testbench for deadband_dosing_controller_top.
// Depends on ddc_pkg and the controller RTL; a status scoreboard predicts every word.
`timescale 1ns / 1ps

module tb_deadband_dosing_controller_top;
  import ddc_pkg::*;

  localparam int RING_SIZE = RING_DEPTH_DEF;
  localparam int LONG_HOLD = 400;

  // expected status after one input word
  typedef struct {
    dir_t        dose;
    logic        up_on;
    logic        down_on;
    logic [15:0] measure;
    mode_t       state;
  } dosing_status_t;

  // Tracks controller state, predicts status words and checks the ones that come back
  class dosing_status_board;
    logic [15:0] set_point, error_margin, settle_margin, dose_time;
    logic [23:0] settle_time, sample_period;
    logic [1:0]  pump_enable;
    logic        manual_mode;
    logic [15:0] ring [RING_SIZE];
    int unsigned wr_pos;
    logic [15:0] mean;
    mode_t       mode;
    logic [23:0] since_sample, since_dose;
    logic [15:0] pulse_left;
    dir_t        pulse_dir;
    dosing_status_t status_due[$];
    int unsigned errors, checked, words, kept, doses_up, doses_down;

    function new();
      set_point = '0; error_margin = '0; settle_margin = '0; dose_time = '0;
      settle_time = '0; sample_period = '0; pump_enable = '0; manual_mode = 1'b0;
      foreach (ring[j]) ring[j] = '0;
      wr_pos = 0; mean = '0; mode = MODE_STABLE;
      since_sample = '0; since_dose = '0; pulse_left = '0; pulse_dir = DIR_NONE;
      errors = 0; checked = 0; words = 0; kept = 0; doses_up = 0; doses_down = 0;
    endfunction

    function int unsigned pending();
      return status_due.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] data);
      case (cfg_idx_t'(idx))
        REG_SET_POINT:     set_point = data[15:0];
        REG_ERROR_MARGIN:  error_margin = data[15:0];
        REG_SETTLE_MARGIN: settle_margin = data[15:0];
        REG_SETTLE_TIME:   settle_time = data;
        REG_DOSE_TIME:     dose_time = data[15:0];
        REG_SAMPLE_PERIOD: sample_period = data;
        REG_PUMP_ENABLE:   pump_enable = data[1:0];
        REG_MANUAL_MODE:   manual_mode = data[0];
        default: ;
      endcase
    endfunction

    // advance the controller by one accepted word and queue its status
    function void accept_word(logic [1:0] k, logic [15:0] v);
      dosing_status_t want;
      dir_t        started;
      int unsigned total;
      int          err, mag;
      started = DIR_NONE;
      words++;
      case (k)
        KIND_TICK: begin
          if (since_sample != CNT_SAT) since_sample = since_sample + 1'b1;
          // settle wait only runs once the pulse is over
          if (pulse_left != 0) begin
            pulse_left = pulse_left - 1'b1;
            since_dose = '0;
            if (pulse_left == 0) pulse_dir = DIR_NONE;
          end else if (since_dose != CNT_SAT) begin
            since_dose = since_dose + 1'b1;
          end
        end
        KIND_SAMPLE: begin
          if (since_sample > sample_period) begin
            since_sample = '0;
            ring[wr_pos] = v;
            wr_pos = (wr_pos + 1) % RING_SIZE;
            total = 0;
            foreach (ring[j]) total += ring[j];
            mean = 16'(total / RING_SIZE);
            kept++;
          end
        end
        KIND_CONTROL: begin
          err = int'(mean) - int'(set_point);
          mag = (err < 0) ? -err : err;
          if (manual_mode) begin
            mode = MODE_STABLE;
          end else begin
            case (mode)
              MODE_STABLE: begin
                if (mag >= error_margin && mean != 0) mode = MODE_CONTROLLING;
              end
              MODE_CONTROLLING: begin
                if (mag >= settle_margin) begin
                  if (err > 0 && mean != 0 && pump_enable[1]) started = DIR_DOWN;
                  else if (err < 0 && mean != 0 && pump_enable[0]) started = DIR_UP;
                  // a new dose replaces any running pulse
                  if (started != DIR_NONE) begin
                    pulse_dir = (dose_time == 0) ? DIR_NONE : started;
                    pulse_left = dose_time;
                  end
                  mode = MODE_STABILIZING;
                  since_dose = '0;
                end else begin
                  mode = MODE_STABLE;
                end
              end
              MODE_STABILIZING: begin
                if (since_dose > settle_time) mode = MODE_CONTROLLING;
              end
              default: mode = MODE_STABLE;
            endcase
          end
          if (started == DIR_UP) doses_up++;
          if (started == DIR_DOWN) doses_down++;
        end
        default: ;
      endcase
      want.dose    = started;
      want.up_on   = (pulse_dir == DIR_UP && pulse_left != 0);
      want.down_on = (pulse_dir == DIR_DOWN && pulse_left != 0);
      want.measure = mean;
      want.state   = mode;
      status_due.push_back(want);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on status word %0d, %s: expected %0d, got %0d",
                   checked, field, want, got);
      end
    endfunction

    function void check_status(logic [1:0] dose, logic up_on, logic down_on,
                               logic [15:0] measure, logic [1:0] state);
      dosing_status_t want;
      if (status_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("status word with no input outstanding: dose %0d measure %0d state %0d",
                   dose, measure, state);
        return;
      end
      want = status_due.pop_front();
      compare("dose_direction", want.dose, dose);
      compare("pump_up_on", want.up_on, up_on);
      compare("pump_down_on", want.down_on, down_on);
      compare("average_measure", want.measure, measure);
      compare("control_state", want.state, state);
      checked++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [1:0]  kind = KIND_NOP;
  logic [15:0] sample_value = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  dose_direction;
  logic        pump_up_on;
  logic        pump_down_on;
  logic [15:0] average_measure;
  logic [1:0]  control_state;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  logic        stall_request = 1'b0;
  logic [23:0] settings [8];
  int unsigned burst_left = 0;
  int unsigned words_sent = 0;
  int unsigned settings_used = 0;
  int unsigned short_period = 0;
  int          aim = 0;
  int          spread = 0;

  dosing_status_board sb = new();

  deadband_dosing_controller_top i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // observe every handshake on all three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready)
        sb.check_status(dose_direction, pump_up_on, pump_down_on, average_measure,
                        control_state);
      if (item_valid && item_ready) sb.accept_word(kind, sample_value);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // result side: stall styles in random stretches, plus one long hold on request
  initial begin : result_side
    int unsigned run_left, style;
    logic        hold_done;
    run_left = 0;
    style = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request && !hold_done) begin
        hold_done = 1'b1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (run_left == 0) begin
          style = $urandom_range(0, 3);
          run_left = $urandom_range(10, 150);
        end
        run_left--;
        case (style)
          0:       result_ready <= 1'b1;
          1:       result_ready <= 1'($urandom_range(0, 1));
          2:       result_ready <= ($urandom_range(0, 3) == 0);
          default: result_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // offer one word, wait for it to be taken, then maybe start a gap
  task automatic send_word(kind_t k, logic [15:0] v);
    int unsigned gap;
    item_valid <= 1'b1;
    kind <= k;
    sample_value <= v;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (k != KIND_NOP) words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(0, 25);
    end
  endtask

  // stop sending and wait until every status word is back
  task automatic drain_results;
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write all eight registers back to back, block idle
  task automatic apply_settings;
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= settings[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
    short_period = (settings[REG_SAMPLE_PERIOD] > 24'd4) ? 4
                                                         : int'(settings[REG_SAMPLE_PERIOD]);
  endtask

  // sample near the current aim, with some extremes and full-range values
  function automatic logic [15:0] pick_sample();
    int          v;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 16'h0000;
    if (roll < 10) return 16'hFFFF;
    if (roll < 25) return 16'($urandom_range(0, 65535));
    v = aim - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // mostly tick/sample/tick/control sequences, some long tick runs and noise
  task automatic run_traffic(int unsigned n);
    int unsigned start, k, roll;
    start = words_sent;
    while (words_sent - start < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        k = $urandom_range(0, short_period + 2);
        repeat (k) send_word(KIND_TICK, 16'($urandom_range(0, 65535)));
        send_word(KIND_SAMPLE, pick_sample());
        k = $urandom_range(0, 4);
        repeat (k) send_word(KIND_TICK, 16'($urandom_range(0, 65535)));
        send_word(KIND_CONTROL, 16'($urandom_range(0, 65535)));
        if ($urandom_range(0, 3) == 0)
          send_word(KIND_CONTROL, 16'($urandom_range(0, 65535)));
      end else if (roll < 78) begin
        k = $urandom_range(8, 30);
        repeat (k) send_word(KIND_TICK, 16'($urandom_range(0, 65535)));
      end else if (roll < 95) begin
        send_word(kind_t'($urandom_range(0, 2)), pick_sample());
      end else begin
        send_word(KIND_NOP, 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    foreach (settings[j]) settings[j] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: empty ring, zero margins, no pumps
    send_word(KIND_NOP, 16'hFFFF);
    send_word(KIND_CONTROL, 16'h0000);  // zero measure keeps it stable
    send_word(KIND_SAMPLE, 16'h1234);   // no tick since reset, dropped
    send_word(KIND_TICK, 16'h0000);
    send_word(KIND_SAMPLE, 16'hFFFF);   // kept
    send_word(KIND_SAMPLE, 16'hFFFF);   // too soon, dropped
    send_word(KIND_CONTROL, 16'h0000);  // to controlling
    send_word(KIND_CONTROL, 16'h0000);  // no pump present: stabilizing without a dose
    send_word(KIND_CONTROL, 16'h0000);  // settle wait not over
    send_word(KIND_TICK, 16'h0000);
    send_word(KIND_CONTROL, 16'h0000);

    // both pumps, zero dose time: dose reported, no pump driven
    drain_results;
    settings[REG_PUMP_ENABLE] = 24'd3;
    apply_settings;
    send_word(KIND_CONTROL, 16'h0000);
    send_word(KIND_TICK, 16'h0000);
    send_word(KIND_CONTROL, 16'h0000);

    // measure below set point: up pulse
    drain_results;
    settings[REG_SET_POINT] = 24'hFFFF;
    settings[REG_DOSE_TIME] = 24'd4;
    apply_settings;
    send_word(KIND_CONTROL, 16'h0000);
    send_word(KIND_TICK, 16'h0000);

    // manual mode mid-pulse: forced stable, pulse keeps running
    drain_results;
    settings[REG_MANUAL_MODE] = 24'd1;
    apply_settings;
    send_word(KIND_CONTROL, 16'h0000);
    send_word(KIND_TICK, 16'h0000);

    // back to automatic: a second dose replaces the running pulse
    drain_results;
    settings[REG_MANUAL_MODE] = 24'd0;
    apply_settings;
    send_word(KIND_CONTROL, 16'h0000);
    send_word(KIND_CONTROL, 16'h0000);
    repeat (5) send_word(KIND_TICK, 16'h0000);
    send_word(KIND_CONTROL, 16'h0000);

    // random phases over a spread of settings
    for (phase = 0; phase < 10; phase++) begin
      drain_results;
      case (phase)
        0: begin
          settings[REG_SET_POINT]     = 24'($urandom_range(1500, 2500));
          settings[REG_ERROR_MARGIN]  = 24'($urandom_range(50, 200));
          settings[REG_SETTLE_MARGIN] = settings[REG_ERROR_MARGIN] +
                                        24'($urandom_range(0, 300));
          settings[REG_SETTLE_TIME]   = 24'($urandom_range(0, 6));
          settings[REG_DOSE_TIME]     = 24'($urandom_range(1, 4));
          settings[REG_SAMPLE_PERIOD] = 24'($urandom_range(0, 2));
          settings[REG_PUMP_ENABLE]   = 24'd3;
          settings[REG_MANUAL_MODE]   = 24'd0;
          aim = int'(settings[REG_SET_POINT]);
          spread = 600;
        end
        1: begin
          // zero margins, up pump only: every dose is an up dose
          settings[REG_SET_POINT]     = 24'($urandom_range(0, 65535));
          settings[REG_ERROR_MARGIN]  = 24'd0;
          settings[REG_SETTLE_MARGIN] = 24'd0;
          settings[REG_SETTLE_TIME]   = 24'd0;
          settings[REG_DOSE_TIME]     = 24'd1;
          settings[REG_SAMPLE_PERIOD] = 24'd0;
          settings[REG_PUMP_ENABLE]   = 24'd1;
          aim = int'($urandom_range(0, 65535));
          spread = 20000;
        end
        2: begin
          // widest margins, reachable only with a full-scale ring
          settings[REG_SET_POINT]     = 24'd0;
          settings[REG_ERROR_MARGIN]  = 24'hFFFF;
          settings[REG_SETTLE_MARGIN] = 24'hFFFF;
          settings[REG_SETTLE_TIME]   = 24'($urandom_range(0, 3));
          settings[REG_DOSE_TIME]     = 24'd2;
          settings[REG_SAMPLE_PERIOD] = 24'd0;
          settings[REG_PUMP_ENABLE]   = 24'd3;
          aim = 65535;
          spread = 0;
        end
        3: begin
          // longest times: samples never kept, pulse never ends here
          settings[REG_SET_POINT]     = 24'hFFFF;
          settings[REG_ERROR_MARGIN]  = 24'($urandom_range(0, 500));
          settings[REG_SETTLE_MARGIN] = 24'($urandom_range(0, 1000));
          settings[REG_SETTLE_TIME]   = 24'hFFFFFF;
          settings[REG_DOSE_TIME]     = 24'hFFFF;
          settings[REG_SAMPLE_PERIOD] = 24'hFFFFFF;
          settings[REG_PUMP_ENABLE]   = 24'd1;
        end
        4: begin
          // manual with the long pulse still running
          settings[REG_SET_POINT]     = 24'($urandom_range(0, 65535));
          settings[REG_ERROR_MARGIN]  = 24'($urandom_range(0, 100));
          settings[REG_SETTLE_MARGIN] = 24'($urandom_range(0, 100));
          settings[REG_SETTLE_TIME]   = 24'd1;
          settings[REG_DOSE_TIME]     = 24'd2;
          settings[REG_SAMPLE_PERIOD] = 24'($urandom_range(0, 1));
          settings[REG_PUMP_ENABLE]   = 24'd3;
          settings[REG_MANUAL_MODE]   = 24'd1;
          aim = int'(settings[REG_SET_POINT]);
          spread = 3000;
        end
        6: begin
          // no pumps: doses fall through to the settle wait
          settings[REG_SET_POINT]     = 24'($urandom_range(0, 65535));
          settings[REG_ERROR_MARGIN]  = 24'($urandom_range(0, 100));
          settings[REG_SETTLE_MARGIN] = 24'($urandom_range(0, 100));
          settings[REG_SETTLE_TIME]   = 24'($urandom_range(0, 8));
          settings[REG_DOSE_TIME]     = 24'($urandom_range(0, 5));
          settings[REG_SAMPLE_PERIOD] = 24'($urandom_range(0, 3));
          settings[REG_PUMP_ENABLE]   = 24'd0;
          settings[REG_MANUAL_MODE]   = 24'd0;
          aim = int'(settings[REG_SET_POINT]);
          spread = 2000;
        end
        default: begin
          settings[REG_SET_POINT]     = 24'($urandom_range(1000, 64000));
          settings[REG_ERROR_MARGIN]  = 24'($urandom_range(0, 65535) >> $urandom_range(0, 12));
          settings[REG_SETTLE_MARGIN] = 24'($urandom_range(0, 65535) >> $urandom_range(0, 12));
          settings[REG_SETTLE_TIME]   = 24'($urandom_range(0, 15));
          settings[REG_DOSE_TIME]     = 24'($urandom_range(0, 10));
          settings[REG_SAMPLE_PERIOD] = 24'($urandom_range(0, 5));
          settings[REG_PUMP_ENABLE]   = 24'($urandom_range(0, 3));
          settings[REG_MANUAL_MODE]   = 24'($urandom_range(0, 5) == 0);
          aim = int'(settings[REG_SET_POINT]);
          spread = int'(settings[REG_SETTLE_MARGIN]) + 200;
        end
      endcase
      apply_settings;
      // long result hold while words keep coming: input side must back up
      if (phase == 0) stall_request <= 1'b1;
      run_traffic((phase == 3) ? 60 : 122);
    end

    drain_results;
    repeat (16) @(posedge clk);
    $display("Covered %0d words over %0d register settings, %0d samples kept,",
             words_sent, settings_used, sb.kept);
    $display("%0d up and %0d down doses; %0d status words checked, %0d field mismatches.",
             sb.doses_up, sb.doses_down, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS deadband_dosing_controller_top");
    end else begin
      $display("FAIL deadband_dosing_controller_top");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin : watchdog
    #3_000_000;
    $display("FAIL deadband_dosing_controller_top");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ddc_pkg.sv
hdl/ddc_ctrl.sv
hdl/ddc_datapath.sv
hdl/deadband_dosing_controller_top.sv
hdl/ddc_checker.sv
tb/tb_deadband_dosing_controller_top.sv
